// ----- src/bounded_deque_assert.svh -----
// ----------------------------------------------------------------------------
// bounded_deque_assert.svh
// Assertion macros used by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ASSERT_SVH
`define BOUNDED_DEQUE_ASSERT_SVH

// clocked check, masked while reset is asserted
`define BDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// clocked check that also holds during reset
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- src/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants for the bounded deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int CFG_W  = 5;
    localparam int KIND_W = 3;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_QUERY      = 3'd4
    } t_bdq_kind;

    // per-cycle shift control broadcast to every cell, already qualified by ok
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } t_bdq_ctl;

endpackage

`default_nettype wire

// ----- src/bdq_cell.sv -----
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the deque chain: data word plus occupancy bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire bdq_pkg::t_bdq_ctl i_ctl,
    input  wire  [DATA_WIDTH-1:0] i_push_value,
    input  wire  [DATA_WIDTH-1:0] i_prev_data,
    input  wire                   i_prev_occ,
    input  wire  [DATA_WIDTH-1:0] i_next_data,
    input  wire                   i_next_occ,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_occ,
    output logic [DATA_WIDTH-1:0] o_last_data
);
    import bdq_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_occ;
    logic                  n_occ;

    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        if (i_ctl.push_front) begin
            n_data = i_prev_data;
            n_occ  = i_prev_occ;
        end else if (i_ctl.push_back) begin
            // first free slot takes the new word
            if (!r_occ && i_prev_occ) begin
                n_data = i_push_value;
            end
            n_occ = i_prev_occ;
        end else if (i_ctl.pop_front) begin
            n_data = i_next_data;
            n_occ  = i_next_occ;
        end else if (i_ctl.pop_back) begin
            n_occ = i_next_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_data      = r_data;
    assign o_occ       = r_occ;
    // last occupied cell drives the back word, others give zero
    assign o_last_data = (r_occ && !i_next_occ) ? r_data : '0;

endmodule

`default_nettype wire

// ----- src/bounded_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue with a programmable capacity, built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_kind and i_push_value with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   busy is always low, so a request may be issued in every cycle.
//   Kinds: push front, push back, pop front, pop back, query (5..7 = query).
//   Result channel: o_done is high for exactly one cycle per request, with
//   o_ok, o_entry_count, o_is_empty, o_is_full, o_front_value, o_back_value
//   describing the queue after that request. The receiver cannot stall.
//   Sequence: the request edge updates the cells, the next edge registers
//   the result, which is then on the ports for one cycle. Throughput: one
//   request per cycle, set by the cell chain, in which a front push or pop
//   shifts every word by one slot at once.
//   Configuration: i_cfg_we with i_cfg_wdata sets the capacity limit; the
//   effective capacity is min(limit, DEPTH). Write only while idle.
//   Reset (synchronous, active low): queue empty, capacity limit 16, no
//   result pending. Slot data is not cleared; only occupied slots are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // request channel
    input  wire                          start,
    output logic                         busy,
    input  wire  [bdq_pkg::KIND_W-1:0]   i_kind,
    input  wire  [DATA_WIDTH-1:0]        i_push_value,
    // configuration
    input  wire                          i_cfg_we,
    input  wire  [bdq_pkg::CFG_W-1:0]    i_cfg_wdata,
    // result channel
    output logic                         o_done,
    output logic                         o_ok,
    output logic [$clog2(DEPTH + 1)-1:0] o_entry_count,
    output logic                         o_is_empty,
    output logic                         o_is_full,
    output logic [DATA_WIDTH-1:0]        o_front_value,
    output logic [DATA_WIDTH-1:0]        o_back_value
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // ---- control state ----
    logic [CFG_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_held;
    logic [CNT_W-1:0]  n_held;
    logic              r_pend;
    logic              r_pend_ok;
    logic              n_ok;
    t_bdq_ctl          w_ctl;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;

    // ---- cell chain ----
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic                  w_occ  [DEPTH];
    logic [DATA_WIDTH-1:0] w_last [DEPTH];
    logic [DATA_WIDTH-1:0] w_back;

    // ---- result registers ----
    logic                  r_done;
    logic                  r_ok;
    logic [CNT_W-1:0]      r_count;
    logic                  r_is_empty;
    logic                  r_is_full;
    logic [DATA_WIDTH-1:0] r_front;
    logic [DATA_WIDTH-1:0] r_back;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // held >= min(cap, DEPTH); held never exceeds DEPTH
    assign w_full  = (CMP_W'(r_held) >= CMP_W'(r_cap)) || (r_held == CNT_W'(DEPTH));
    assign w_empty = (r_held == '0);

    // decode the request into shift controls; refused ops leave the chain alone
    always_comb begin
        w_ctl  = '0;
        n_ok   = 1'b1;
        n_held = r_held;
        if (w_accept) begin
            case (t_bdq_kind'(i_kind))
                KIND_PUSH_FRONT: begin
                    n_ok             = !w_full;
                    w_ctl.push_front = !w_full;
                    if (!w_full) n_held = r_held + 1'b1;
                end
                KIND_PUSH_BACK: begin
                    n_ok            = !w_full;
                    w_ctl.push_back = !w_full;
                    if (!w_full) n_held = r_held + 1'b1;
                end
                KIND_POP_FRONT: begin
                    n_ok            = !w_empty;
                    w_ctl.pop_front = !w_empty;
                    if (!w_empty) n_held = r_held - 1'b1;
                end
                KIND_POP_BACK: begin
                    n_ok           = !w_empty;
                    w_ctl.pop_back = !w_empty;
                    if (!w_empty) n_held = r_held - 1'b1;
                end
                default: begin
                    n_ok = 1'b1; // query and unused kinds
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_held    <= '0;
            r_pend    <= 1'b0;
            r_pend_ok <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_held    <= n_held;
            r_pend    <= w_accept;
            r_pend_ok <= n_ok;
            r_done    <= r_pend;
        end
    end

    // Cell 0 sees the push word as its left neighbor and is always "behind"
    // an occupied slot; the last cell sees an empty right neighbor.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_prev_data;
            logic                  w_prev_occ;
            logic [DATA_WIDTH-1:0] w_next_data;
            logic                  w_next_occ;

            if (g == 0) begin : g_head
                assign w_prev_data = i_push_value;
                assign w_prev_occ  = 1'b1;
            end else begin : g_mid_prev
                assign w_prev_data = w_data[g-1];
                assign w_prev_occ  = w_occ[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_data = '0;
                assign w_next_occ  = 1'b0;
            end else begin : g_mid_next
                assign w_next_data = w_data[g+1];
                assign w_next_occ  = w_occ[g+1];
            end

            bdq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_push_value (i_push_value),
                .i_prev_data  (w_prev_data),
                .i_prev_occ   (w_prev_occ),
                .i_next_data  (w_next_data),
                .i_next_occ   (w_next_occ),
                .o_data       (w_data[g]),
                .o_occ        (w_occ[g]),
                .o_last_data  (w_last[g])
            );
        end
    endgenerate

    // exactly one cell is last when non-empty, none when empty
    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | w_last[i];
        end
    end

    // result register: snapshot of the chain after the request settled
    always_ff @(posedge i_clk) begin
        r_ok       <= r_pend_ok;
        r_count    <= r_held;
        r_is_empty <= !w_occ[0];
        r_is_full  <= w_full;
        r_front    <= w_occ[0] ? w_data[0] : '0;
        r_back     <= w_back;
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_entry_count = r_count;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;

    // ---- assertions ----
`include "bounded_deque_assert.svh"

    `BDQ_ASSERT(a_one_result, (start && !busy) |-> ##2 o_done, "request without result")
    `BDQ_ASSERT(a_count_bound, r_held <= CNT_W'(DEPTH), "entry count beyond depth")
    `BDQ_ASSERT(a_head_occ, w_occ[0] == (r_held != '0), "head occupancy disagrees with count")
    `BDQ_ASSERT(a_refused_keeps, (r_pend && !r_pend_ok) |-> (r_held == $past(r_held)), "refused request changed count")

endmodule

`default_nettype wire

// ----- sim/tb_bounded_deque.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_deque
// Self-checking bench for the bounded deque. A scoreboard class keeps its
// own ring-buffer copy of the queue and the capacity limit, predicts the
// result of every accepted request and compares it with each o_done
// strobe. A short directed part covers the corner cases, then random
// push/pop bursts run under several capacity settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_deque;
    import bdq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int LIMIT_CYCLES = 100000;
    // request edge (cells update) -> result register edge, plus margin
    localparam int SETTLE       = 8;
    localparam int MAX_REPORTS  = 10;

    // one result word as the block reports it
    typedef struct packed {
        logic                  ok;
        logic [CNT_W-1:0]      entry_count;
        logic                  is_empty;
        logic                  is_full;
        logic [DATA_WIDTH-1:0] front_value;
        logic [DATA_WIDTH-1:0] back_value;
    } t_deque_result;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the deque plus the queue of predicted results.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [DATA_WIDTH-1:0] slots [DEPTH];
        int unsigned           head;
        int unsigned           held;
        logic [CFG_W-1:0]      cap_limit;
        t_deque_result         predicted_q [$];
        int                    mismatches;

        function new();
            head       = 0;
            held       = 0;
            cap_limit  = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            cap_limit = value;
        endfunction

        function int unsigned pending();
            return predicted_q.size();
        endfunction

        // apply one request to the mirror and queue the state it leaves
        function void note_request(logic [KIND_W-1:0] kind, logic [DATA_WIDTH-1:0] value);
            int unsigned   cap;
            logic          was_full;
            logic          was_empty;
            t_deque_result res;
            cap       = (cap_limit > DEPTH) ? DEPTH : cap_limit;
            was_full  = (held >= cap);
            was_empty = (held == 0);
            res.ok    = 1'b1;
            case (kind)
                KIND_PUSH_FRONT: begin
                    if (was_full) begin
                        res.ok = 1'b0;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slots[head] = value;
                        held++;
                    end
                end
                KIND_PUSH_BACK: begin
                    if (was_full) begin
                        res.ok = 1'b0;
                    end else begin
                        slots[(head + held) % DEPTH] = value;
                        held++;
                    end
                end
                KIND_POP_FRONT: begin
                    if (was_empty) begin
                        res.ok = 1'b0;
                    end else begin
                        head = (head + 1) % DEPTH;
                        held--;
                    end
                end
                KIND_POP_BACK: begin
                    if (was_empty) begin
                        res.ok = 1'b0;
                    end else begin
                        held--;
                    end
                end
                default: begin
                    // query and the unused codes leave the queue alone
                end
            endcase
            res.entry_count = held[CNT_W-1:0];
            res.is_empty    = (held == 0);
            res.is_full     = (held >= cap);
            res.front_value = (held != 0) ? slots[head] : '0;
            res.back_value  = (held != 0) ? slots[(head + held - 1) % DEPTH] : '0;
            predicted_q.push_back(res);
        endfunction

        function void check_result(t_deque_result got);
            t_deque_result want;
            if (predicted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with no request pending: %p", got);
                return;
            end
            want = predicted_q.pop_front();
            if (got.ok !== want.ok || got.entry_count !== want.entry_count ||
                got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
                got.front_value !== want.front_value ||
                got.back_value !== want.back_value) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result mismatch");
                    $display("  expected ok=%0b cnt=%0d empty=%0b full=%0b front=%h back=%h",
                             want.ok, want.entry_count, want.is_empty, want.is_full,
                             want.front_value, want.back_value);
                    $display("  actual   ok=%0b cnt=%0d empty=%0b full=%0b front=%h back=%h",
                             got.ok, got.entry_count, got.is_empty, got.is_full,
                             got.front_value, got.back_value);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its stimulus signals
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [KIND_W-1:0]     i_kind;
    logic [DATA_WIDTH-1:0] i_push_value;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  o_done;
    logic                  o_ok;
    logic [CNT_W-1:0]      o_entry_count;
    logic                  o_is_empty;
    logic                  o_is_full;
    logic [DATA_WIDTH-1:0] o_front_value;
    logic [DATA_WIDTH-1:0] o_back_value;

    deque_scoreboard sb;
    int              idle_pct;

    bounded_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_push_value  (i_push_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, where the DUT's
    // registered outputs still hold the values of the cycle just ending.
    // Results go to the checker before new requests are noted; the result
    // of a request never shows up on its own accept edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result('{o_ok, o_entry_count, o_is_empty, o_is_full,
                                  o_front_value, o_back_value});
            // capacity write lands on this edge; the bench only writes while idle
            if (i_cfg_we)
                sb.set_capacity(i_cfg_wdata);
            if (start && !busy)
                sb.note_request(i_kind, i_push_value);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks: inputs change on the falling edge only.
    // ------------------------------------------------------------------------

    // present one request, hold it until the block takes it
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [DATA_WIDTH-1:0] value);
        int gap;
        // random sender gaps ahead of the request
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_kind       <= kind;
        i_push_value <= value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // only called right after wait_for_results, so start is low
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= CFG_W'($urandom);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // burst mode 0 leans to pushes, 1 to pops, 2 is even; ~10% query/unused
    function automatic logic [KIND_W-1:0] pick_kind(int mode);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return KIND_W'($urandom_range(KIND_QUERY, 7));
        r = $urandom_range(99);
        case (mode)
            0:       return (r < 75) ? KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_BACK))
                                     : KIND_W'($urandom_range(KIND_POP_FRONT, KIND_POP_BACK));
            1:       return (r < 75) ? KIND_W'($urandom_range(KIND_POP_FRONT, KIND_POP_BACK))
                                     : KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_BACK));
            default: return KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_POP_BACK));
        endcase
    endfunction

    // mostly legal limits, with zero, one, full depth and above-depth mixed in
    function automatic logic [CFG_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(99);
        if (r < 10)      return 5'd0;
        else if (r < 20) return 5'd1;
        else if (r < 35) return 5'd16;
        else if (r < 45) return CFG_W'($urandom_range(17, 31));
        else             return CFG_W'($urandom_range(2, 15));
    endfunction

    // random fill / drain bursts so the queue walks between empty and full
    task automatic run_random(input int count);
        int mode;
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            mode  = $urandom_range(2);
            burst = $urandom_range(4, 12);
            repeat (burst) begin
                if (sent < count) begin
                    send_request(pick_kind(mode), pick_value());
                    sent++;
                end
            end
        end
    endtask

    // corner cases, starting from reset (capacity 16, empty)
    task automatic run_directed();
        send_request(KIND_QUERY, 32'h0);
        send_request(KIND_POP_FRONT, 32'h0);        // pop on empty, refused
        send_request(KIND_POP_BACK, 32'hFFFF_FFFF);
        send_request(KIND_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(KIND_PUSH_FRONT, 32'h0000_0000);
        send_request(KIND_PUSH_BACK, 32'hA5A5_A5A5);
        send_request(KIND_PUSH_FRONT, 32'h5A5A_5A5A); // head already wrapped below slot 0 by the earlier front push
        send_request(3'd5, 32'h1111_1111);          // unused codes act as query
        send_request(3'd6, 32'h2222_2222);
        send_request(3'd7, 32'h3333_3333);
        send_request(KIND_POP_FRONT, 32'h0);
        send_request(KIND_POP_BACK, 32'h0);
        send_request(KIND_POP_FRONT, 32'h0);
        send_request(KIND_POP_BACK, 32'h0);
        // capacity of one: second push refused
        wait_for_results();
        write_capacity(5'd1);
        send_request(KIND_PUSH_BACK, 32'h1234_5678);
        send_request(KIND_PUSH_FRONT, 32'h8765_4321);
        send_request(KIND_POP_FRONT, 32'h0);
        // capacity zero: full while empty, pushes refused
        wait_for_results();
        write_capacity(5'd0);
        send_request(KIND_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(KIND_PUSH_BACK, 32'hCAFE_F00D);
        send_request(KIND_QUERY, 32'h0);
        // limit above depth, clamps to 16
        wait_for_results();
        write_capacity(5'd31);
        send_request(KIND_PUSH_FRONT, 32'h0000_0001);
        send_request(KIND_PUSH_BACK, 32'h8000_0000);
        send_request(KIND_PUSH_BACK, 32'h7FFF_FFFF);
        // limit dropped under the count: entries stay, pushes refused
        wait_for_results();
        write_capacity(5'd2);
        send_request(KIND_PUSH_BACK, 32'h5555_5555);
        send_request(KIND_POP_BACK, 32'h0);
        send_request(KIND_PUSH_FRONT, 32'hAAAA_AAAA);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb           = new();
        idle_pct     = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = '0;
        i_push_value = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // three idle patterns: sender gaps 30%, then 46%, then none.
        // Each pattern runs four blocks under a fresh capacity; the drain in
        // front of each write is the full pause of the sender.
        for (int phase = 0; phase < 3; phase++) begin
            for (int blk = 0; blk < 4; blk++) begin
                wait_for_results();
                if (phase == 0 && blk == 0)
                    write_capacity(5'd16);
                else if (phase == 1 && blk == 0)
                    write_capacity(5'd31);
                else
                    write_capacity(pick_capacity());
                idle_pct = (phase == 0) ? 30 : (phase == 1) ? 46 : 0;
                run_random(54);
            end
        end

        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("bounded_deque test passed");
        end else begin
            $display("bounded_deque test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("bounded_deque test failed");
        $finish;
    end

endmodule
